// File: rtl/core/mfpc_pkg.sv
// Shared types, constants and register codes for the motor fader position controller.
package mfpc_pkg;

  // Number of faders held in the state RAM
  localparam int unsigned FADERS = 2;
  // Width of the fader id field on the item channel
  localparam int unsigned FaderIdW = 1;

  // APB register map, one 32-bit word per register
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    REG_MAX_ERROR      = 3'd0,
    REG_BRAKE_DISTANCE = 3'd1,
    REG_SLOW_DUTY      = 3'd2,
    REG_FAST_DUTY      = 3'd3,
    REG_DEADSPOT_BASE  = 3'd4
  } cfg_reg_e;

  // H-bridge pin drive state
  typedef enum logic [1:0] {
    PIN_OFF  = 2'b00,
    PIN_UP   = 2'b01,
    PIN_DOWN = 2'b10
  } pin_e;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SET    = 1'b1;

  // Target reset value
  localparam logic [9:0] TargetReset = 10'd30;

  // Input beat
  typedef struct packed {
    logic       req_type;
    logic       fader_id;
    logic [9:0] sample;
    logic [7:0] target_level;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic        out_fader;
    logic        motor_up;
    logic        motor_down;
    logic [7:0]  duty;
    logic        moving;
    logic [11:0] raw_position;
    logic [7:0]  level;
  } out_item_t;

  // Configuration registers
  typedef struct packed {
    logic [5:0] max_error;
    logic [9:0] brake_distance;
    logic [7:0] slow_duty;
    logic [7:0] fast_duty;
    logic [5:0] deadspot_base;
  } cfg_t;

  // One fader's servo state, one RAM word
  typedef struct packed {
    logic [9:0] cur_pos;
    logic [9:0] target_pos;
    logic       is_moving;
    logic       going_up;
    pin_e       pins;
    logic [7:0] duty;
  } entry_t;

  localparam entry_t EntryReset = '{
    cur_pos:    10'd0,
    target_pos: TargetReset,
    is_moving:  1'b0,
    going_up:   1'b0,
    pins:       PIN_OFF,
    duty:       8'd0
  };

  // Item held between the RAM read and the write-back
  typedef struct packed {
    logic       req_type;
    logic       fader_id;
    logic       fader_ok;
    logic [9:0] sample;
    logic [9:0] target_pos;
  } pipe_t;

endpackage

// File: rtl/core/motor_fader_position_control.sv
// Top level of the motor fader position controller.
//
// Items come in on the in_* channel (valid/stall): a sample beat carries one
// fader's ADC reading, a set beat carries a 0..255 target level. Every beat
// gives exactly one result beat on the out_* channel, in order, reporting
// that fader's drive pins, duty, moving flag, stored position and level.
// User must write APB settings with no beat in flight; block doesn't enforce.
//
// Per-fader state sits in a small synchronous RAM. A beat reads its fader's
// word on the accepting edge, the update is computed in the next cycle and
// written back while the result enters the output register; a bypass feeds a
// back-to-back beat for the same fader. The result passes the update stage
// and the output register; one beat is taken every cycle while no output
// stall holds the pipeline, each beat reading and writing back the state RAM.
// A stall on the output holds the result register and the beat behind it;
// in_stall_o rises once both are full. Reset empties the pipeline, restores
// the settings and makes every fader read as idle with target 30.
module motor_fader_position_control import mfpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Item channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  // APB settings port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Level to raw target: 209/64 slope low, 156/31 slope high
  function automatic logic [9:0] target_of(input logic [7:0] lv);
    logic [15:0] p1;
    logic [5:0]  d;
    logic [20:0] p2;
    logic [9:0]  tgt;
    p1 = 16'(lv) * 16'd209;
    d  = 6'(lv - 8'd193);
    p2 = 21'(d) * 21'd20613;
    if (lv <= 8'd192) begin
      tgt = p1[15:6] + TargetReset;
    end else begin
      tgt = 10'(p2[20:12]) + 10'd658;
    end
    return tgt;
  endfunction

  cfg_t      cfg;
  entry_t    rd_entry, wr_entry;
  out_item_t result;
  pipe_t     s1_q, s1_d;
  logic      s1_valid_q;
  logic      s1_adv, in_acc, ram_we;
  logic      out_valid_q;
  out_item_t out_item_q;

  mfpc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the update stage moves on whenever the output register frees up
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ram_we     = s1_valid_q && s1_adv && s1_q.fader_ok;

  // Item registered alongside the RAM read; target mapped on the way in
  always_comb begin
    s1_d.req_type   = in_item_i.req_type;
    s1_d.fader_id   = in_item_i.fader_id;
    s1_d.fader_ok   = ({31'd0, in_item_i.fader_id} < FADERS);
    s1_d.sample     = in_item_i.sample;
    s1_d.target_pos = target_of(in_item_i.target_level);
  end

  mfpc_state_ram u_state_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (in_acc),
    .raddr_i (in_item_i.fader_id),
    .we_i    (ram_we),
    .waddr_i (s1_q.fader_id),
    .wdata_i (wr_entry),
    .rdata_o (rd_entry)
  );

  mfpc_servo_calc u_servo_calc (
    .item_i   (s1_q),
    .entry_i  (rd_entry),
    .cfg_i    (cfg),
    .entry_o  (wr_entry),
    .result_o (result)
  );

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s1_adv) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && s1_valid_q))
    else $error("input stalled while the pipeline has room");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat lost before the update stage");

  a_pins_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.motor_up && out_item_q.motor_down))
    else $error("both H-bridge pins driven");

  a_idle_pins_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.moving) |-> (!out_item_q.motor_up && !out_item_q.motor_down))
    else $error("idle fader still driving its motor");

endmodule

// File: rtl/core/mfpc_cfg_regs.sv
// APB register file for the servo settings.
module mfpc_cfg_regs import mfpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_ERROR:      cfg_d.max_error      = pwdata[5:0];
        REG_BRAKE_DISTANCE: cfg_d.brake_distance = pwdata[9:0];
        REG_SLOW_DUTY:      cfg_d.slow_duty      = pwdata[7:0];
        REG_FAST_DUTY:      cfg_d.fast_duty      = pwdata[7:0];
        REG_DEADSPOT_BASE:  cfg_d.deadspot_base  = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_error      <= 6'd4;
      cfg_q.brake_distance <= 10'd40;
      cfg_q.slow_duty      <= 8'd100;
      cfg_q.fast_duty      <= 8'd190;
      cfg_q.deadspot_base  <= 6'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_MAX_ERROR:      prdata = CfgDataW'(cfg_q.max_error);
      REG_BRAKE_DISTANCE: prdata = CfgDataW'(cfg_q.brake_distance);
      REG_SLOW_DUTY:      prdata = CfgDataW'(cfg_q.slow_duty);
      REG_FAST_DUTY:      prdata = CfgDataW'(cfg_q.fast_duty);
      REG_DEADSPOT_BASE:  prdata = CfgDataW'(cfg_q.deadspot_base);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/mfpc_state_ram.sv
// Per-fader state RAM: registered synchronous read, write bypass, reset valid bits.
module mfpc_state_ram import mfpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                re_i,
  input  logic [FaderIdW-1:0] raddr_i,
  input  logic                we_i,
  input  logic [FaderIdW-1:0] waddr_i,
  input  entry_t              wdata_i,
  output entry_t              rdata_o
);

  entry_t             mem_q [FADERS];
  entry_t             rdata_q;
  logic [FADERS-1:0]  vld_q;
  logic               rvld_q;
  logic               bypass;

  // Same-entry write and read in the same cycle: hand the new word straight on
  assign bypass = we_i && (waddr_i == raddr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (bypass) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  // Entries never written read as the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= bypass || vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : EntryReset;

endmodule

// File: rtl/core/mfpc_servo_calc.sv
// Servo update: target window, drive pins, duty, deadband and level mapping.
module mfpc_servo_calc import mfpc_pkg::*; (
  input  pipe_t     item_i,
  input  entry_t    entry_i,
  input  cfg_t      cfg_i,
  output entry_t    entry_o,
  output out_item_t result_o
);

  // Raw position to 0..255 level, reciprocal multiplies for the constant divides
  function automatic logic [7:0] level_of(input logic [9:0] p);
    logic [9:0]  x;
    logic [8:0]  z;
    logic [24:0] m1;
    logic [20:0] m2;
    logic [7:0]  lvl;
    x   = p - 10'd60;
    z   = 9'(p - 10'd658);
    m1  = 25'(x) * 25'd21077;   // x*64/199
    m2  = 21'(z) * 21'd3256;    // z*31/156
    if (p < 10'd60) begin
      lvl = 8'd0;
    end else if (p <= 10'd657) begin
      lvl = m1[23:16];
    end else if (p <= 10'd970) begin
      lvl = 8'(m2[20:14]) + 8'd193;
    end else begin
      lvl = 8'd255;
    end
    return lvl;
  endfunction

  logic [9:0]  c, t, old_pos;
  logic [10:0] c_ext, t_ext, me_ext;
  logic        hit_up, hit_dn, hit, reached;
  logic [9:0]  tgt_dist, moved;
  logic [7:0]  band_thr, duty_new;
  logic        hold;

  assign c       = item_i.sample;
  assign t       = entry_i.target_pos;
  assign old_pos = entry_i.cur_pos;
  assign c_ext   = {1'b0, c};
  assign t_ext   = {1'b0, t};
  assign me_ext  = 11'(cfg_i.max_error);

  // Target window depends on the direction of travel
  assign hit_up  = (c >= t) && (c_ext <= t_ext + me_ext);
  assign hit_dn  = (c <= t) && (c_ext + me_ext >= t_ext);
  assign hit     = entry_i.going_up ? hit_up : hit_dn;
  assign reached = entry_i.is_moving && hit;

  // Brake distance picks the duty
  assign tgt_dist = (c > t) ? (c - t) : (t - c);
  assign duty_new = (tgt_dist <= cfg_i.brake_distance) ? cfg_i.slow_duty : cfg_i.fast_duty;

  // Deadband grows by one base step per 500 counts of position
  always_comb begin
    if (c >= 10'd1000) begin
      band_thr = 8'({cfg_i.deadspot_base, 1'b0}) + 8'(cfg_i.deadspot_base);
    end else if (c >= 10'd500) begin
      band_thr = 8'({cfg_i.deadspot_base, 1'b0});
    end else begin
      band_thr = 8'(cfg_i.deadspot_base);
    end
  end

  // Once the target is reached the deadband is bypassed, so the new reading is never held
  assign moved = (c > old_pos) ? (c - old_pos) : (old_pos - c);
  assign hold  = !reached && (moved <= 10'(band_thr));

  // Next state of the fader
  always_comb begin
    entry_o = entry_i;
    if (item_i.req_type == REQ_SAMPLE) begin
      if (entry_i.is_moving) begin
        if (hit) begin
          entry_o.pins      = PIN_OFF;
          entry_o.is_moving = 1'b0;
        end else if (c > t) begin
          entry_o.pins = PIN_DOWN;
        end else if (c < t) begin
          entry_o.pins = PIN_UP;
        end
        entry_o.duty = duty_new;
      end
      entry_o.cur_pos = hold ? old_pos : c;
    end else begin
      entry_o.is_moving  = 1'b1;
      entry_o.target_pos = item_i.target_pos;
      entry_o.going_up   = item_i.target_pos > old_pos;
    end
  end

  // Result beat
  always_comb begin
    result_o           = '0;
    result_o.out_fader = item_i.fader_id;
    if (item_i.fader_ok) begin
      result_o.motor_up     = (entry_o.pins == PIN_UP);
      result_o.motor_down   = (entry_o.pins == PIN_DOWN);
      result_o.duty         = entry_o.duty;
      result_o.moving       = entry_o.is_moving;
      result_o.raw_position = 12'(entry_o.cur_pos);
      result_o.level        = level_of(entry_o.cur_pos);
    end
  end

endmodule
